// ----- src/mexp_pkg.sv -----
// Shared types and constants of the modular exponentiation core.
// No dependencies.
`default_nettype none
package mexp_pkg;
   localparam int RESIDUE_BITS_DEF = 64;
   localparam int EXP_BITS = 64;
   localparam int FIELD_BITS = 64;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;
endpackage
`default_nettype wire

// ----- src/mexp_cell.sv -----
// One cell of the exponent chain: holds one exponent bit, loads it or takes
// its lower neighbor's bit. Depends on mexp_pkg.
`default_nettype none
module mexp_cell (
   input  wire                    clock,
   input  wire mexp_pkg::cell_ctrl_type ctrl,
   input  wire                    load_bit,
   input  wire                    next_bit,
   output logic                   q
);
   logic bit_ff, bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (ctrl.load) begin
         bit_in = load_bit;
      end else if (ctrl.shift) begin
         bit_in = next_bit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign q = bit_ff;
endmodule
`default_nettype wire

// ----- src/mexp_mulmod.sv -----
// Bit-serial modular multiplier: acc = 2*acc + b_i*a mod m, one multiplier
// bit per cycle, most significant first. Depends on mexp_pkg.
`default_nettype none
module mexp_mulmod #(
   parameter int W = mexp_pkg::RESIDUE_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   input  wire  [W-1:0] a,
   input  wire  [W-1:0] b,
   input  wire  [W-1:0] m,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] result
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff, acc_in, b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    dbl, dred, sum, sred;

   always_comb begin
      dbl  = {acc_ff, 1'b0};
      dred = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
      sum  = dred + {1'b0, a};
      sred = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
      acc_in  = acc_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         b_in   = b;
         cnt_in = CW'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = b_ff[W-1] ? sred[W-1:0] : dred[W-1:0];
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      b_ff   <= b_in;
   end

   assign busy   = run_ff;
   assign done   = done_ff;
   assign result = acc_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(run_ff)) else $error("done without a running product");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      run_ff && cnt_ff != CW'(1) |=> run_ff || done) else $error("product dropped");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      !(run_ff && done_ff)) else $error("done while still running");
endmodule
`default_nettype wire

// ----- src/modular_exponentiation_core.sv -----
// Top level of the modular exponentiation core: control sequencer, exponent
// cell chain and shared multiplier. Depends on mexp_pkg, mexp_cell, mexp_mulmod.
//
// Computes req_base ^ req_exponent mod modulus by left-to-right square and
// multiply. An item is taken when start is high and busy is low; the result
// appears on rsp_* for one cycle with rsp_valid and cannot be stalled, so the
// receiver must take it then. Processing: a leading-zero scan of the exponent
// down to its top set bit, then per remaining exponent bit one squaring plus
// one multiply on a one bit, each on the bit-serial multiplier.
// An out-of-range base or zero exponent is answered straight from idle. The
// user must write the modulus over the csr_ port only while busy is low;
// the block itself does not enforce this.
`default_nettype none
module modular_exponentiation_core #(
   parameter int RESIDUE_BITS = mexp_pkg::RESIDUE_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire  [mexp_pkg::FIELD_BITS-1:0]  req_base,
   input  wire  [mexp_pkg::EXP_BITS-1:0]    req_exponent,
   output logic                             rsp_valid,
   output logic [mexp_pkg::FIELD_BITS-1:0]  rsp_power,
   output logic                             rsp_base_out_of_range,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [mexp_pkg::FIELD_BITS-1:0]  csr_data
);
   localparam int W  = RESIDUE_BITS;
   localparam int E  = mexp_pkg::EXP_BITS;
   localparam int CW = $clog2(E + 1);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_NEXT = 3'd2;
   localparam logic [2:0] S_SQ   = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [W-1:0]  modulus_ff, modulus_in, t_ff, t_in, base_ff, base_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          vld_ff, vld_in, oor_ff, oor_in;
   logic [mexp_pkg::FIELD_BITS-1:0] pow_ff, pow_in;
   logic [E-1:0]  exp_q;
   mexp_pkg::cell_ctrl_type cctl;
   logic          mm_start, mm_busy, mm_done;
   logic [W-1:0]  mm_b, mm_res;
   logic          accept;

   assign accept    = start && !busy;
   assign busy      = state_ff != S_IDLE;
   assign csr_ready = 1'b1;

   for (genvar i = 0; i < E; i++) begin : g_cell
      logic nb;
      if (i == 0) begin : g_lo
         assign nb = 1'b0;
      end else begin : g_up
         assign nb = exp_q[i-1];
      end
      mexp_cell u_cell (
         .clock(clock), .ctrl(cctl), .load_bit(req_exponent[i]),
         .next_bit(nb), .q(exp_q[i])
      );
   end

   mexp_mulmod #(.W(W)) u_mul (
      .clock(clock), .reset(reset), .start(mm_start), .a(t_ff), .b(mm_b),
      .m(modulus_ff), .busy(mm_busy), .done(mm_done), .result(mm_res)
   );

   always_comb begin
      state_in   = state_ff;
      modulus_in = modulus_ff;
      t_in       = t_ff;
      base_in    = base_ff;
      cnt_in     = cnt_ff;
      vld_in     = 1'b0;
      oor_in     = oor_ff;
      pow_in     = pow_ff;
      cctl       = '0;
      mm_start   = 1'b0;
      mm_b       = t_ff;
      if (csr_valid && csr_ready) begin
         modulus_in = csr_data[W-1:0];
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cctl.load = 1'b1;
               base_in   = req_base[W-1:0];
               t_in      = req_base[W-1:0];
               cnt_in    = CW'(E);
               if (req_base >= mexp_pkg::FIELD_BITS'(modulus_ff)) begin
                  vld_in = 1'b1;
                  oor_in = 1'b1;
                  pow_in = '0;
               end else if (req_exponent == '0) begin
                  vld_in = 1'b1;
                  oor_in = 1'b0;
                  pow_in = (modulus_ff == W'(1)) ? '0 : mexp_pkg::FIELD_BITS'(1);
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cctl.shift = 1'b1;
            cnt_in     = cnt_ff - 1'b1;
            if (exp_q[E-1]) begin
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (cnt_ff == '0) begin
               vld_in   = 1'b1;
               oor_in   = 1'b0;
               pow_in   = mexp_pkg::FIELD_BITS'(t_ff);
               state_in = S_IDLE;
            end else begin
               mm_start = 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (mm_done) begin
               t_in = mm_res;
               if (exp_q[E-1]) begin
                  state_in = S_MUL;
               end else begin
                  cctl.shift = 1'b1;
                  cnt_in     = cnt_ff - 1'b1;
                  state_in   = S_NEXT;
               end
            end
         end
         S_MUL: begin
            mm_b = base_ff;
            if (!mm_busy && !mm_done) begin
               mm_start = 1'b1;
            end
            if (mm_done) begin
               t_in       = mm_res;
               cctl.shift = 1'b1;
               cnt_in     = cnt_ff - 1'b1;
               state_in   = S_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         modulus_ff <= W'(1);
         vld_ff     <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         modulus_ff <= modulus_in;
         vld_ff     <= vld_in;
         cnt_ff     <= cnt_in;
      end
      t_ff    <= t_in;
      base_ff <= base_in;
      oor_ff  <= oor_in;
      pow_ff  <= pow_in;
   end

   assign rsp_valid             = vld_ff;
   assign rsp_power             = pow_ff;
   assign rsp_base_out_of_range = oor_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE) else $error("result while busy");
   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mm_busy |-> state_ff == S_SQ || state_ff == S_MUL)
      else $error("multiplier running outside product states");
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || rsp_valid) else $error("transfer produced nothing");
endmodule
`default_nettype wire
